FILE: rtl/dcit_pkg.sv
// dcit_pkg: shared types and constants of the dual interval timer
// register offsets, control bit positions, opcodes and transfer payloads
// no dependencies
package dcit_pkg;

    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int FLAG_W  = 2;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register map offsets
    localparam logic [3:0] REG_ALL_ONES = 4'd1;
    localparam logic [3:0] REG_TA_LO    = 4'd4;
    localparam logic [3:0] REG_TA_HI    = 4'd5;
    localparam logic [3:0] REG_TB_LO    = 4'd6;
    localparam logic [3:0] REG_TB_HI    = 4'd7;
    localparam logic [3:0] REG_ICR      = 4'd13;
    localparam logic [3:0] REG_CRA      = 4'd14;
    localparam logic [3:0] REG_CRB      = 4'd15;

    // control byte bits
    localparam int CTRL_RUN     = 0;
    localparam int CTRL_ONESHOT = 3;
    localparam int CTRL_CASCADE = 6;
    localparam int ICR_SETCLR   = 7;

    localparam logic [BYTE_W-1:0]  READ_ALL_ONES = 8'hff;
    localparam logic [COUNT_W-1:0] COUNT_WRAP    = 16'hffff;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        reg_offset;
        logic [BYTE_W-1:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              irq_pulse;
        logic [FLAG_W-1:0] status_flags;
    } out_item_t;

    // next state of one timer after a tick
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  control;
        logic               wrap;
    } timer_next_t;

endpackage

FILE: rtl/dcit_in_if.sv
// dcit_in_if: valid/ready channel carrying one timer command item
// depends on dcit_pkg
interface dcit_in_if;
    logic                valid;
    logic                ready;
    dcit_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dcit_out_if.sv
// dcit_out_if: valid/ready channel carrying one timer result item
// depends on dcit_pkg
interface dcit_out_if;
    logic                valid;
    logic                ready;
    dcit_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dual_cascadable_interval_timer.sv
// dual_cascadable_interval_timer: top level of the two-timer block
// handshake control and result register; depends on dcit_pkg, dcit_in_if,
// dcit_out_if and dcit_core
//
//   channel | direction | payload                                 | handshake
//   --------+-----------+-----------------------------------------+-----------
//   cmd     | in        | opcode, reg_offset, write_byte          | valid/ready
//   rsp     | out       | read_byte, irq_pulse, status_flags      | valid/ready
//
// one command item per clock while rsp does not stall; its result is held in
// the result register from the cycle after the transfer, set by the single pass through dcit_core
// rst_n clears all timer state, the mask and the wrap flags, and empties the
// result register
// a new command is taken while the result register is empty or being drained
// in the same cycle, so a stalled rsp holds cmd only once the register is full
module dual_cascadable_interval_timer (
    input  logic       clk,
    input  logic       rst_n,
    dcit_in_if.sink    cmd,
    dcit_out_if.source rsp
);
    import dcit_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    out_item_t result;
    logic      take;

    // command transfer: free slot or the held result leaves this cycle
    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign take      = cmd.valid && cmd.ready;

    // state update and result computation for the item in transfer
    dcit_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (take),
        .item   (cmd.data),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: rtl/dcit_timer.sv
// dcit_timer: next-state logic of one 16-bit down counter for one tick
// depends on dcit_pkg
module dcit_timer (
    input  logic [15:0]          count,
    input  logic [7:0]           control,
    input  logic [15:0]          reload,
    input  logic                 enable,
    output dcit_pkg::timer_next_t nxt
);
    import dcit_pkg::*;

    logic [COUNT_W-1:0] dec;
    logic               wrap;

    assign dec  = count - COUNT_W'(1);
    assign wrap = enable && (dec == COUNT_WRAP);

    always_comb
    begin
        nxt.count   = count;
        nxt.control = control;
        nxt.wrap    = wrap;
        if (enable)
        begin
            nxt.count = dec;
        end
        if (wrap)
        begin
            if (control[CTRL_ONESHOT])
            begin
                // one-shot: stop, counter stays at all ones
                nxt.control[CTRL_RUN] = 1'b0;
            end
            else
            begin
                nxt.count = reload;
            end
        end
    end

endmodule

FILE: rtl/dcit_core.sv
// dcit_core: timer state registers, bus register map and timer cascade
// depends on dcit_pkg and dcit_timer
module dcit_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  dcit_pkg::in_item_t  item,
    output dcit_pkg::out_item_t result
);
    import dcit_pkg::*;

    logic [COUNT_W-1:0] count_a_reg, count_a_next;
    logic [COUNT_W-1:0] count_b_reg, count_b_next;
    logic [COUNT_W-1:0] reload_a_reg, reload_a_next;
    logic [COUNT_W-1:0] reload_b_reg, reload_b_next;
    logic [BYTE_W-1:0]  control_a_reg, control_a_next;
    logic [BYTE_W-1:0]  control_b_reg, control_b_next;
    logic [BYTE_W-1:0]  irq_enable_reg, irq_enable_next;
    logic [FLAG_W-1:0]  wrap_flags_reg, wrap_flags_next;

    logic        is_tick, is_read, is_write;
    logic        en_a, en_b;
    timer_next_t tmr_a, tmr_b;
    logic [BYTE_W-1:0] rd_byte;

    assign is_tick  = (item.opcode == OP_TICK);
    assign is_read  = (item.opcode == OP_READ);
    assign is_write = (item.opcode == OP_WRITE);

    assign en_a = is_tick && control_a_reg[CTRL_RUN];
    // cascade mode counts only the timer a wrap of this tick
    assign en_b = is_tick && control_b_reg[CTRL_RUN]
               && (!control_b_reg[CTRL_CASCADE] || tmr_a.wrap);

    dcit_timer u_timer_a (
        .count   (count_a_reg),
        .control (control_a_reg),
        .reload  (reload_a_reg),
        .enable  (en_a),
        .nxt     (tmr_a)
    );

    dcit_timer u_timer_b (
        .count   (count_b_reg),
        .control (control_b_reg),
        .reload  (reload_b_reg),
        .enable  (en_b),
        .nxt     (tmr_b)
    );

    always_comb
    begin
        rd_byte = '0;
        case (item.reg_offset)
            REG_ALL_ONES: rd_byte = READ_ALL_ONES;
            REG_TA_LO:    rd_byte = count_a_reg[7:0];
            REG_TA_HI:    rd_byte = count_a_reg[15:8];
            REG_TB_LO:    rd_byte = count_b_reg[7:0];
            REG_TB_HI:    rd_byte = count_b_reg[15:8];
            default:      rd_byte = '0;
        endcase
    end

    always_comb
    begin
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        reload_a_next   = reload_a_reg;
        reload_b_next   = reload_b_reg;
        control_a_next  = control_a_reg;
        control_b_next  = control_b_reg;
        irq_enable_next = irq_enable_reg;
        wrap_flags_next = wrap_flags_reg;
        if (is_tick)
        begin
            count_a_next    = tmr_a.count;
            control_a_next  = tmr_a.control;
            count_b_next    = tmr_b.count;
            control_b_next  = tmr_b.control;
            wrap_flags_next = wrap_flags_reg | {tmr_b.wrap, tmr_a.wrap};
        end
        else if (is_write)
        begin
            case (item.reg_offset)
                REG_TA_LO: reload_a_next[7:0]  = item.write_byte;
                REG_TA_HI: reload_a_next[15:8] = item.write_byte;
                REG_TB_LO: reload_b_next[7:0]  = item.write_byte;
                REG_TB_HI: reload_b_next[15:8] = item.write_byte;
                REG_ICR:
                begin
                    if (item.write_byte[ICR_SETCLR])
                    begin
                        irq_enable_next = irq_enable_reg | item.write_byte;
                    end
                    else
                    begin
                        irq_enable_next = irq_enable_reg & ~item.write_byte;
                    end
                end
                REG_CRA:   control_a_next = item.write_byte;
                REG_CRB:   control_b_next = item.write_byte;
                default:   ;
            endcase
        end
    end

    assign result.read_byte    = is_read ? rd_byte : '0;
    assign result.irq_pulse    = tmr_a.wrap && irq_enable_reg[0];
    assign result.status_flags = wrap_flags_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            reload_a_reg   <= '0;
            reload_b_reg   <= '0;
            control_a_reg  <= '0;
            control_b_reg  <= '0;
            irq_enable_reg <= '0;
            wrap_flags_reg <= '0;
        end
        else if (go)
        begin
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            reload_a_reg   <= reload_a_next;
            reload_b_reg   <= reload_b_next;
            control_a_reg  <= control_a_next;
            control_b_reg  <= control_b_next;
            irq_enable_reg <= irq_enable_next;
            wrap_flags_reg <= wrap_flags_next;
        end
    end

endmodule
